### sv/twcw_pkg.sv
// text window console writer: shared types and constants
// transaction payload structs, register map, opcodes and control characters
// no dependencies
package twcw_pkg;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_LEFT   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [4:0] TOP_RST    = 5'd2;
  localparam logic [6:0] LEFT_RST   = 7'd0;
  localparam logic [6:0] WIDTH_RST  = 7'd80;
  localparam logic [4:0] HEIGHT_RST = 5'd24;

  // opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] BLANK  = 8'h20;

  typedef struct packed {
    logic [4:0] window_top;
    logic [6:0] window_left;
    logic [6:0] window_width;
    logic [4:0] window_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_address;
    logic [4:0]  cursor_line;
    logic [6:0]  cursor_column;
    logic [7:0]  read_char;
  } out_t;

endpackage

### sv/twcw_cfg_regs.sv
// text window console writer: apb-style window configuration registers
// depends on twcw_pkg (register map, reset values, cfg_t)
module twcw_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twcw_pkg::CFG_AW-1:0] paddr,
  input  logic [twcw_pkg::CFG_DW-1:0] pwdata,
  output logic [twcw_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output twcw_pkg::cfg_t              cfg,
  output logic                        cfg_wr
);

  twcw_pkg::cfg_t cfg_r;
  twcw_pkg::cfg_t cfg_nxt;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        twcw_pkg::REG_TOP:    cfg_nxt.window_top    = pwdata[4:0];
        twcw_pkg::REG_LEFT:   cfg_nxt.window_left   = pwdata[6:0];
        twcw_pkg::REG_WIDTH:  cfg_nxt.window_width  = pwdata[6:0];
        twcw_pkg::REG_HEIGHT: cfg_nxt.window_height = pwdata[4:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      twcw_pkg::REG_TOP:    prdata = twcw_pkg::CFG_DW'(cfg_r.window_top);
      twcw_pkg::REG_LEFT:   prdata = twcw_pkg::CFG_DW'(cfg_r.window_left);
      twcw_pkg::REG_WIDTH:  prdata = twcw_pkg::CFG_DW'(cfg_r.window_width);
      twcw_pkg::REG_HEIGHT: prdata = twcw_pkg::CFG_DW'(cfg_r.window_height);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_top    <= twcw_pkg::TOP_RST;
      cfg_r.window_left   <= twcw_pkg::LEFT_RST;
      cfg_r.window_width  <= twcw_pkg::WIDTH_RST;
      cfg_r.window_height <= twcw_pkg::HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/twcw_screen_ram.sv
// text window console writer: screen character store
// one write port, one read port with registered read data; no dependencies
module twcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

### sv/text_window_console_writer_unit.sv
// text window console writer: top level sequencer around the screen store
// depends on twcw_pkg, twcw_cfg_regs, twcw_screen_ram
//
// usage
//   in_data carries one command transaction (put character, read cell, clear
//   window); every command gives exactly one out_data transaction holding the
//   cursor position after the command and, for a read, the cell byte.
//   the window is set through the apb-style port; out-of-screen values are
//   clamped, zero width or height counts as one.
// sequencing
//   put of a plain character, backspace, newline without scroll and the
//   unused opcode: result loaded into the output register on acceptance,
//   one command per cycle while the receiver does not stall. read: memory
//   read, capture, result. tab: blanks to the tab stop, then the result.
//   clear: blanks the window, then the result. scroll copies rows up, one
//   store cell per cycle through the single read and write port of the screen store.
// reset
//   a clearing pass writes a space into all SCREEN_ROWS*SCREEN_COLS cells
//   with in_stall high; register writes still land.
// stalls
//   the result sits in an output register; while out_valid and out_stall are
//   high it holds and no new command is taken. in_stall is also high during a
//   register write and after it while the write passes through hold_r, as the window geometry settles.
module text_window_console_writer_unit #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80,
  parameter int TAB_STOP    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  twcw_pkg::in_t               in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output twcw_pkg::out_t              out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twcw_pkg::CFG_AW-1:0] paddr,
  input  logic [twcw_pkg::CFG_DW-1:0] pwdata,
  output logic [twcw_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(SCREEN_ROWS + 1);
  localparam int CW         = $clog2(SCREEN_COLS + 1);
  // tab stop arithmetic: quotient by reciprocal multiply, exact for col < 2**CW
  localparam int TW         = CW + $clog2(TAB_STOP + 1);
  localparam int SH         = CW + $clog2(TAB_STOP) + 1;
  localparam int RECIP      = (2 ** SH + TAB_STOP - 1) / TAB_STOP;
  localparam int PW         = CW + SH + 1;

  typedef enum logic [6:0] {
    S_INIT       = 7'b0000001,
    S_IDLE       = 7'b0000010,
    S_READ       = 7'b0000100,
    S_FILL       = 7'b0001000,
    S_SCROLL     = 7'b0010000,
    S_SCROLL_END = 7'b0100000,
    S_FINISH     = 7'b1000000
  } state_t;

  // configuration
  twcw_pkg::cfg_t cfg;
  logic           cfg_wr;
  logic [1:0]     hold_r;

  twcw_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // screen store
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  twcw_screen_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // clamped window, one register stage behind the config registers; base and bottom addresses two
  logic [RW-1:0] top_c, room_rows, h_c;
  logic [CW-1:0] left_c, room_cols, w_c;
  logic [4:0]    h0;
  logic [6:0]    w0;
  logic [RW-1:0] win_top_r, win_h_r;
  logic [CW-1:0] win_left_r, win_w_r;
  logic [AW-1:0] win_base_r, win_bot_r;

  always_comb begin
    top_c  = (32'(cfg.window_top) < 32'(SCREEN_ROWS - 1)) ?
             RW'(cfg.window_top) : RW'(SCREEN_ROWS - 1);
    left_c = (32'(cfg.window_left) < 32'(SCREEN_COLS - 1)) ?
             CW'(cfg.window_left) : CW'(SCREEN_COLS - 1);
    h0        = (cfg.window_height == 5'd0) ? 5'd1 : cfg.window_height;
    w0        = (cfg.window_width == 7'd0) ? 7'd1 : cfg.window_width;
    room_rows = RW'(SCREEN_ROWS) - top_c;
    room_cols = CW'(SCREEN_COLS) - left_c;
    h_c       = (32'(h0) > 32'(room_rows)) ? room_rows : RW'(h0);
    w_c       = (32'(w0) > 32'(room_cols)) ? room_cols : CW'(w0);
  end

  always_ff @(posedge clk) begin
    win_top_r  <= top_c;
    win_left_r <= left_c;
    win_h_r    <= h_c;
    win_w_r    <= w_c;
    win_base_r <= AW'(win_top_r) * AW'(SCREEN_COLS) + AW'(win_left_r);
    win_bot_r  <= AW'(win_top_r + win_h_r - RW'(1)) * AW'(SCREEN_COLS) + AW'(win_left_r);
  end

  // sequencer state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  init_addr_r, init_addr_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  // blank fill walker (tab, clear, bottom row after scroll)
  logic [AW-1:0]  fill_base_r, fill_base_nxt;
  logic [CW-1:0]  fill_col_r, fill_col_nxt;
  logic [CW-1:0]  fill_lo_r, fill_lo_nxt;
  logic [CW-1:0]  fill_last_r, fill_last_nxt;
  logic [RW-1:0]  fill_rows_r, fill_rows_nxt;
  logic           pend_scroll_r, pend_scroll_nxt;
  // scroll copy walker, destination row base and column
  logic [AW-1:0]  sc_base_r, sc_base_nxt;
  logic [CW-1:0]  sc_col_r, sc_col_nxt;
  logic [RW-1:0]  sc_rows_r, sc_rows_nxt;
  logic           wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]  wr_addr_r, wr_addr_nxt;
  // read result
  logic           rd_oob_r, rd_oob_nxt;
  logic [7:0]     rd_char_r, rd_char_nxt;
  // output register
  logic           out_valid_r;
  twcw_pkg::out_t out_data_r, out_data_nxt;
  logic           out_load;

  logic           slot_free;
  logic           in_accept;
  logic           go_scroll, go_bottom;

  // per-command cursor math
  logic [RW-1:0]  row_s, row_t, row_w, row_f;
  logic [CW-1:0]  col_s, col_t, col_w, col_f;
  logic [CW-1:0]  tab_end;
  logic [PW-1:0]  tab_prod;
  logic [CW-1:0]  tab_q;
  logic [TW-1:0]  tab_stop_col;
  logic [AW-1:0]  row_s_base;
  logic [AW-1:0]  cell_s_addr;
  logic [AW-1:0]  pos;
  logic           put_wr, is_tab, need_scroll;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (hold_r != 2'b00) || cfg_wr || !slot_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    // cursor brought back inside the window first
    row_s = (cur_row_r >= win_h_r) ? win_h_r - RW'(1) : cur_row_r;
    col_s = (cur_col_r >= win_w_r) ? win_w_r - CW'(1) : cur_col_r;

    // next tab stop, cut at the window width
    tab_prod     = PW'(col_s) * PW'(RECIP);
    tab_q        = CW'(tab_prod >> SH);
    tab_stop_col = (TW'(tab_q) + TW'(1)) * TW'(TAB_STOP);
    tab_end      = (tab_stop_col > TW'(win_w_r)) ? win_w_r : CW'(tab_stop_col);

    row_s_base  = win_base_r + AW'(row_s) * AW'(SCREEN_COLS);
    cell_s_addr = row_s_base + AW'(col_s);

    row_t  = row_s;
    col_t  = col_s;
    put_wr = 1'b0;
    is_tab = 1'b0;
    case (in_data.char_code) inside
      twcw_pkg::CH_BS: begin
        col_t = (col_s != '0) ? col_s - CW'(1) : col_s;
      end
      twcw_pkg::CH_TAB: begin
        col_t  = tab_end;
        is_tab = 1'b1;
      end
      twcw_pkg::CH_LF, twcw_pkg::CH_CR: begin
        col_t = '0;
        row_t = row_s + RW'(1);
      end
      default: begin
        col_t  = col_s + CW'(1);
        put_wr = 1'b1;
      end
    endcase

    // wrap at the window width, scroll past the last row
    if (col_t >= win_w_r) begin
      col_w = '0;
      row_w = row_t + RW'(1);
    end else begin
      col_w = col_t;
      row_w = row_t;
    end
    need_scroll = (row_w >= win_h_r);
    row_f       = need_scroll ? win_h_r - RW'(1) : row_w;
    col_f       = col_w;
  end

  always_comb begin
    state_nxt       = state_r;
    init_addr_nxt   = init_addr_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    fill_base_nxt   = fill_base_r;
    fill_col_nxt    = fill_col_r;
    fill_lo_nxt     = fill_lo_r;
    fill_last_nxt   = fill_last_r;
    fill_rows_nxt   = fill_rows_r;
    pend_scroll_nxt = pend_scroll_r;
    sc_base_nxt     = sc_base_r;
    sc_col_nxt      = sc_col_r;
    sc_rows_nxt     = sc_rows_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    rd_oob_nxt      = rd_oob_r;
    rd_char_nxt     = rd_char_r;
    out_load        = 1'b0;
    go_scroll       = 1'b0;
    go_bottom       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        init_addr_nxt = init_addr_r + AW'(1);
        if (init_addr_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          rd_char_nxt = '0;
          unique case (in_data.opcode)
            twcw_pkg::OP_PUT: begin
              cur_row_nxt = row_f;
              cur_col_nxt = col_f;
              if (is_tab) begin
                fill_base_nxt   = row_s_base;
                fill_col_nxt    = col_s;
                fill_lo_nxt     = col_s;
                fill_last_nxt   = tab_end - CW'(1);
                fill_rows_nxt   = '0;
                pend_scroll_nxt = need_scroll;
                state_nxt       = S_FILL;
              end else if (need_scroll) begin
                go_scroll = 1'b1;
              end else begin
                out_load = 1'b1;
              end
            end
            twcw_pkg::OP_READ: begin
              cur_row_nxt = row_s;
              cur_col_nxt = col_s;
              rd_oob_nxt  = !(32'(in_data.cell_address) < 32'(CELL_COUNT));
              state_nxt   = S_READ;
            end
            twcw_pkg::OP_CLEAR: begin
              cur_row_nxt     = '0;
              cur_col_nxt     = '0;
              fill_base_nxt   = win_base_r;
              fill_col_nxt    = '0;
              fill_lo_nxt     = '0;
              fill_last_nxt   = win_w_r - CW'(1);
              fill_rows_nxt   = win_h_r - RW'(1);
              pend_scroll_nxt = 1'b0;
              state_nxt       = S_FILL;
            end
            default: begin
              cur_row_nxt = row_s;
              cur_col_nxt = col_s;
              out_load    = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rd_char_nxt = rd_oob_r ? 8'd0 : mem_rdata;
        state_nxt   = S_FINISH;
      end
      S_FILL: begin
        fill_col_nxt = fill_col_r + CW'(1);
        if (fill_col_r == fill_last_r) begin
          if (fill_rows_r == '0) begin
            if (pend_scroll_r) begin
              go_scroll = 1'b1;
            end else begin
              state_nxt = S_FINISH;
            end
          end else begin
            fill_base_nxt = fill_base_r + AW'(SCREEN_COLS);
            fill_col_nxt  = fill_lo_r;
            fill_rows_nxt = fill_rows_r - RW'(1);
          end
        end
      end
      S_SCROLL: begin
        // read one row down now, write it back to this row next cycle
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = sc_base_r + AW'(sc_col_r);
        sc_col_nxt  = sc_col_r + CW'(1);
        if (sc_col_r == win_w_r - CW'(1)) begin
          if (sc_rows_r == '0) begin
            state_nxt = S_SCROLL_END;
          end else begin
            sc_base_nxt = sc_base_r + AW'(SCREEN_COLS);
            sc_col_nxt  = '0;
            sc_rows_nxt = sc_rows_r - RW'(1);
          end
        end
      end
      S_SCROLL_END: begin
        go_bottom = 1'b1;
      end
      S_FINISH: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (go_scroll) begin
      pend_scroll_nxt = 1'b0;
      if (win_h_r == RW'(1)) begin
        go_bottom = 1'b1;
      end else begin
        sc_base_nxt = win_base_r;
        sc_col_nxt  = '0;
        sc_rows_nxt = win_h_r - RW'(2);
        state_nxt   = S_SCROLL;
      end
    end

    if (go_bottom) begin
      fill_base_nxt   = win_bot_r;
      fill_col_nxt    = '0;
      fill_lo_nxt     = '0;
      fill_last_nxt   = win_w_r - CW'(1);
      fill_rows_nxt   = '0;
      pend_scroll_nxt = 1'b0;
      state_nxt       = S_FILL;
    end
  end

  // result payload, cursor taken after this cycle's update
  always_comb begin
    pos = win_base_r + AW'(cur_row_nxt) * AW'(SCREEN_COLS) + AW'(cur_col_nxt);
    out_data_nxt.cursor_address = 11'(pos);
    out_data_nxt.cursor_line    = 5'(cur_row_nxt);
    out_data_nxt.cursor_column  = 7'(cur_col_nxt);
    out_data_nxt.read_char      = (state_r == S_FINISH) ? rd_char_r : 8'd0;
  end

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_base_r + AW'(fill_col_r);
    mem_wdata = twcw_pkg::BLANK;
    if (state_r == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = init_addr_r;
    end else if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = mem_rdata;
    end else if (state_r == S_FILL) begin
      mem_we = 1'b1;
    end else if ((state_r == S_IDLE) && in_accept &&
                 (in_data.opcode == twcw_pkg::OP_PUT) && put_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cell_s_addr;
      mem_wdata = in_data.char_code;
    end
    mem_raddr = (state_r == S_SCROLL) ?
                sc_base_r + AW'(SCREEN_COLS) + AW'(sc_col_r) :
                AW'(in_data.cell_address);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      init_addr_r   <= '0;
      cur_row_r     <= '0;
      cur_col_r     <= '0;
      pend_scroll_r <= 1'b0;
      wr_pend_r     <= 1'b0;
      hold_r        <= 2'b00;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      init_addr_r   <= init_addr_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      pend_scroll_r <= pend_scroll_nxt;
      wr_pend_r     <= wr_pend_nxt;
      hold_r        <= {hold_r[0], cfg_wr};
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_base_r <= fill_base_nxt;
    fill_col_r  <= fill_col_nxt;
    fill_lo_r   <= fill_lo_nxt;
    fill_last_r <= fill_last_nxt;
    fill_rows_r <= fill_rows_nxt;
    sc_base_r   <= sc_base_nxt;
    sc_col_r    <= sc_col_nxt;
    sc_rows_r   <= sc_rows_nxt;
    wr_addr_r   <= wr_addr_nxt;
    rd_oob_r    <= rd_oob_nxt;
    rd_char_r   <= rd_char_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### sv/twcw_checker.sv
// text window console writer: port-level checker and its bind
// depends on twcw_pkg and text_window_console_writer_unit
module twcw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input twcw_pkg::in_t               in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input twcw_pkg::out_t              out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [twcw_pkg::CFG_AW-1:0] paddr,
  input logic [twcw_pkg::CFG_DW-1:0] pwdata,
  input logic [twcw_pkg::CFG_DW-1:0] prdata,
  input logic                        pready
);

  logic [1:0] outstanding_r;
  logic [1:0] last_op_r;
  logic       in_xact, out_xact;

  assign in_xact  = in_valid && !in_stall;
  assign out_xact = out_valid && !out_stall;

  // commands taken minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= 2'd0;
      last_op_r     <= twcw_pkg::OP_NONE;
    end else begin
      outstanding_r <= outstanding_r + 2'(in_xact) - 2'(out_xact);
      if (in_xact) begin
        last_op_r <= in_data.opcode;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("command taken during the store clearing pass");

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready |=> in_stall)
    else $error("command taken right after a register write");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (outstanding_r <= 2'd1) && (!out_valid || outstanding_r == 2'd1))
    else $error("result without matching command or two commands in flight");

  a_read_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_char != 8'd0) |-> last_op_r == twcw_pkg::OP_READ)
    else $error("nonzero read_char on a command other than read");

endmodule

bind text_window_console_writer_unit twcw_checker u_twcw_checker (.*);

### tb/sv/twcw_tb_pkg.sv
// text window console writer testbench: screen and cursor tracker class
// predicts the cursor report of every command and checks the results in order
// depends on twcw_pkg
package twcw_tb_pkg;
  import twcw_pkg::*;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int TAB_STOP    = 4;
  localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;

  class console_tracker;
    logic [7:0] screen [CELLS];
    logic [4:0] top_reg;
    logic [6:0] left_reg;
    logic [6:0] width_reg;
    logic [4:0] height_reg;
    int row, col;
    int win_top, win_left, win_w, win_h;
    int last_cursor;
    out_t cursor_reports [$];
    int failures, results_seen;
    int puts, reads, clears, unused_ops, tabs, scrolls;

    function new();
      foreach (screen[i]) screen[i] = BLANK;
      top_reg    = TOP_RST;
      left_reg   = LEFT_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      row = 0;
      col = 0;
      last_cursor = 0;
    endfunction

    function void set_window_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TOP:    top_reg    = value[4:0];
        REG_LEFT:   left_reg   = value[6:0];
        REG_WIDTH:  width_reg  = value[6:0];
        REG_HEIGHT: height_reg = value[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] window_reg(logic [1:0] idx);
      case (idx)
        REG_TOP:    return {27'd0, top_reg};
        REG_LEFT:   return {25'd0, left_reg};
        REG_WIDTH:  return {25'd0, width_reg};
        default:    return {27'd0, height_reg};
      endcase
    endfunction

    function int cell_at(int r, int c);
      return (win_top + r) * SCREEN_COLS + win_left + c;
    endfunction

    function void note_command(in_t cmd);
      int rd_val, pos, r, c;
      out_t report;
      // window clamped to the screen, zero size counts as one
      win_top  = (top_reg < SCREEN_ROWS - 1) ? top_reg : SCREEN_ROWS - 1;
      win_left = (left_reg < SCREEN_COLS - 1) ? left_reg : SCREEN_COLS - 1;
      win_h = (height_reg == 0) ? 1 : height_reg;
      if (win_h > SCREEN_ROWS - win_top) win_h = SCREEN_ROWS - win_top;
      win_w = (width_reg == 0) ? 1 : width_reg;
      if (win_w > SCREEN_COLS - win_left) win_w = SCREEN_COLS - win_left;
      // cursor left outside a shrunk window is pulled back in
      if (row >= win_h) row = win_h - 1;
      if (col >= win_w) col = win_w - 1;
      rd_val = 0;
      case (cmd.opcode)
        OP_PUT: begin
          puts++;
          case (cmd.char_code)
            CH_BS: begin
              if (col > 0) col--;
            end
            CH_TAB: begin
              tabs++;
              screen[cell_at(row, col)] = BLANK;
              col++;
              while (col % TAB_STOP != 0 && col < win_w) begin
                screen[cell_at(row, col)] = BLANK;
                col++;
              end
            end
            CH_LF, CH_CR: begin
              col = 0;
              row++;
            end
            default: begin
              screen[cell_at(row, col)] = cmd.char_code;
              col++;
            end
          endcase
          if (col >= win_w) begin
            col = 0;
            row++;
          end
          if (row >= win_h) begin
            row = win_h - 1;
            scrolls++;
            for (r = 0; r + 1 < win_h; r++)
              for (c = 0; c < win_w; c++)
                screen[cell_at(r, c)] = screen[cell_at(r + 1, c)];
            for (c = 0; c < win_w; c++)
              screen[cell_at(win_h - 1, c)] = BLANK;
          end
        end
        OP_READ: begin
          reads++;
          if (cmd.cell_address < CELLS) rd_val = screen[cmd.cell_address];
        end
        OP_CLEAR: begin
          clears++;
          for (r = 0; r < win_h; r++)
            for (c = 0; c < win_w; c++)
              screen[cell_at(r, c)] = BLANK;
          row = 0;
          col = 0;
        end
        default: unused_ops++;
      endcase
      pos = cell_at(row, col);
      last_cursor = pos;
      report.cursor_address = pos[10:0];
      report.cursor_line    = row[4:0];
      report.cursor_column  = col[6:0];
      report.read_char      = rd_val[7:0];
      cursor_reports.push_back(report);
    endfunction

    function void compare_field(string name, logic [10:0] want, logic [10:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(out_t seen);
      out_t want;
      if (cursor_reports.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, seen);
        failures++;
        return;
      end
      want = cursor_reports.pop_front();
      results_seen++;
      compare_field("cursor_address", want.cursor_address, seen.cursor_address);
      compare_field("cursor_line", {6'd0, want.cursor_line}, {6'd0, seen.cursor_line});
      compare_field("cursor_column", {4'd0, want.cursor_column}, {4'd0, seen.cursor_column});
      compare_field("read_char", {3'd0, want.read_char}, {3'd0, seen.read_char});
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// text window console writer testbench top: clock, reset, drivers and run control
// directed commands first, then random text streams over many window settings
// depends on twcw_pkg, twcw_tb_pkg and text_window_console_writer_unit
module tb_top;
  import twcw_pkg::*;
  import twcw_tb_pkg::*;

  // far above the slowest run this stimulus can make, clears and scrolls included
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int SEGMENTS      = 6;      // window settings per idling phase
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 40;     // quiet time at the end for stray results

  logic clk;
  logic rst_n = 1'b0;

  // command and result channels
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // configuration port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // idling percentages, changed per phase by the main sequence
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // the main sequence bumps the ticket; the receiver serves it once
  int hold_ticket = 0;
  int hold_taken = 0;
  int hold_left = 0;

  int windows = 0;
  int unsigned cycle_count;

  console_tracker board = new();

  text_window_console_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall each cycle, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_ticket != hold_taken) begin
      hold_taken = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still expected",
             $time, cycle_count, board.cursor_reports.size());
    $display("status: fail");
    $finish;
  end

  // one command transaction; called and left at a falling edge, valid stays up
  // so that back-to-back commands go out without a bubble
  task automatic issue(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, char_code: ch, cell_address: addr};
    do @(posedge clk); while (in_stall);
    board.note_command(in_data);
    @(negedge clk);
  endtask

  // stop offering and wait until every cursor report has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.cursor_reports.size() != 0) @(negedge clk);
  endtask

  // apb write, then a read back of the same register
  task automatic write_window_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_window_reg(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== board.window_reg(idx)) begin
      $display("%0t: register %0d read back, expected %0d, got %0d",
               $time, idx, board.window_reg(idx), prdata);
      board.failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // geometry changes only once the block has gone quiet
  task automatic set_window(input int t, input int l, input int w, input int h);
    wait_drained();
    write_window_reg(REG_TOP, t);
    write_window_reg(REG_LEFT, l);
    write_window_reg(REG_WIDTH, w);
    write_window_reg(REG_HEIGHT, h);
    windows++;
  endtask

  // mostly text with control characters, some reads, few clears and unused ops
  task automatic random_command();
    int roll;
    logic [1:0] op;
    logic [7:0] ch;
    logic [10:0] addr;
    roll = $urandom_range(99);
    ch = $urandom_range(255);
    addr = $urandom_range(2047);
    if (roll < 72) begin
      op = OP_PUT;
      roll = $urandom_range(99);
      if (roll < 60) ch = $urandom_range(8'h7E, 8'h20);
      else if (roll < 68) ch = CH_BS;
      else if (roll < 76) ch = CH_TAB;
      else if (roll < 84) ch = roll[0] ? CH_LF : CH_CR;
    end else if (roll < 92) begin
      op = OP_READ;
      // half the reads look just behind the cursor, where text was written
      if ($urandom_range(1) && board.last_cursor >= 3)
        addr = board.last_cursor - $urandom_range(3);
    end else if (roll < 96) begin
      op = OP_NONE;
    end else begin
      op = OP_CLEAR;
    end
    issue(op, ch, addr);
  endtask

  initial begin
    int phase, seg, roll, t, l, w, h;

    // reset; the block's own clearing pass keeps in_stall up afterwards
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset window: reads at the address extremes, byte extremes,
    // backspace down to column zero and past it, tabs, newline, unused opcode
    issue(OP_READ, 8'h00, 11'd0);
    issue(OP_READ, 8'hFF, 11'h7FF);
    issue(OP_PUT, 8'h41, 11'd0);
    issue(OP_PUT, 8'h00, 11'd0);
    issue(OP_PUT, 8'hFF, 11'd0);
    repeat (4) issue(OP_PUT, CH_BS, 11'd0);
    issue(OP_PUT, CH_TAB, 11'd0);
    issue(OP_PUT, CH_LF, 11'd0);
    repeat (3) issue(OP_PUT, CH_TAB, 11'd0);
    issue(OP_NONE, 8'hFF, 11'h7FF);
    issue(OP_READ, 8'h00, 11'd160);

    // narrow window in the bottom right corner: the cursor sits outside it and
    // gets pulled in, a tab stops at the window width (no multiple of the tab stop), every wrap scrolls
    set_window(23, 74, 6, 2);
    issue(OP_PUT, 8'h78, 11'd0);
    issue(OP_PUT, CH_TAB, 11'd0);
    issue(OP_PUT, CH_TAB, 11'd0);
    issue(OP_PUT, CH_CR, 11'd0);
    issue(OP_CLEAR, 8'h00, 11'd0);

    // register values past the screen and zero sizes clamp to a single cell
    set_window(31, 127, 0, 0);
    issue(OP_PUT, 8'h5A, 11'd0);
    issue(OP_READ, 8'h00, 11'd1999);
    issue(OP_CLEAR, 8'h00, 11'd0);

    // oversized width and height clamp to the whole screen
    set_window(0, 0, 127, 31);
    issue(OP_PUT, 8'h7E, 11'd0);
    issue(OP_PUT, CH_BS, 11'd0);

    // random part: three idling phases, several window settings each
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 12 : 0;
      for (seg = 0; seg < SEGMENTS; seg++) begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          // small window, cheap scrolls and clears
          h = $urandom_range(6, 1);
          w = $urandom_range(20, 1);
          t = $urandom_range(SCREEN_ROWS - h);
          l = $urandom_range(SCREEN_COLS - w);
        end else if (roll < 80) begin
          // any register value, clamping included
          t = $urandom_range(31);
          l = $urandom_range(127);
          w = $urandom_range(127);
          h = $urandom_range(31);
        end else begin
          t = $urandom_range(2);
          l = 0;
          w = SCREEN_COLS;
          h = SCREEN_ROWS - t;
        end
        set_window(t, l, w, h);
        // long receiver hold-off with the sender still pushing: fills the block
        if (phase == 2 && seg == 1) hold_ticket++;
        repeat (RANDOM_ITEMS / (3 * SEGMENTS)) random_command();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("ran %0d commands: %0d puts (%0d tabs), %0d reads, %0d clears, %0d unused",
             board.puts + board.reads + board.clears + board.unused_ops, board.puts,
             board.tabs, board.reads, board.clears, board.unused_ops);
    $display("%0d scrolls over %0d window settings, %0d results checked, %0d failures",
             board.scrolls, windows, board.results_seen, board.failures);
    if (board.failures == 0 && board.cursor_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
